>>> design/utf8r_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8r_pkg: shared types and functions of the UTF-8 stream repair block
// Byte classification, sequence repair and the queue entry types.
// ---------------------------------------------------------------------------
package utf8r_pkg;

    // Default width of the repaired-length counter
    localparam int LENGTH_BITS_DEF = 32;
    // Width of the repaired-length field on the output
    localparam int LEN_W = 32;
    // Output queue depth and pointer width
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    // Most bytes one input item can produce
    localparam int MAX_EMIT = 4;

    // One output item as it sits in the queue
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             last;
        logic [7:0]       data;
    } t_entry;

    // Group of items pushed into the queue in one cycle
    typedef struct packed {
        logic [2:0]                  num;
        t_entry [MAX_EMIT-1:0]       ent;
    } t_push;

    // Repaired sequence, byte 0 in the low lane
    typedef logic [3:0][7:0] t_seq;

    // Count of leading ones of a byte (0..8)
    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        priority casez (b)
            8'b0???????: n = 4'd0;
            8'b10??????: n = 4'd1;
            8'b110?????: n = 4'd2;
            8'b1110????: n = 4'd3;
            8'b11110???: n = 4'd4;
            8'b111110??: n = 4'd5;
            8'b1111110?: n = 4'd6;
            8'b11111110: n = 4'd7;
            default:     n = 4'd8;
        endcase
        return n;
    endfunction

    // Force a byte into the 10xxxxxx continuation form
    function automatic logic [7:0] as_follower(input logic [7:0] b);
        return {2'b10, b[5:0]};
    endfunction

    // Repair a complete sequence of 2..4 bytes; lanes past its end pass as given
    function automatic t_seq repair_seq(input t_seq s, input logic [2:0] len);
        t_seq       r;
        logic [3:0] ones;
        logic [7:0] c0;
        logic [7:0] c1;
        r    = s;
        ones = lead_ones(s[0]);
        c0   = s[0];
        r[1] = as_follower(s[1]);
        if (len >= 3'd3) begin
            r[2] = as_follower(s[2]);
        end
        if (len >= 3'd4) begin
            r[3] = as_follower(s[3]);
        end
        c1 = r[1];
        if (ones == 4'd1 || ones == 4'd2) begin
            // lone continuation becomes a 2-byte lead; overlong lead gets bit 1
            if (ones == 4'd1) begin
                c0 = (c0 & 8'b00011111) | 8'b11000000;
            end
            if ((c0 & 8'b00011110) == 8'd0) begin
                c0 = c0 | 8'b00000010;
            end
        end else if (ones == 4'd3) begin
            // overlong 3-byte form and surrogate range
            if (c0[3:0] == 4'd0 && c1[5] == 1'b0) begin
                c1 = c1 | 8'b00100000;
            end
            if (c0[3:0] == 4'b1101 && c1[5] == 1'b1) begin
                c1 = c1 & 8'b11011111;
            end
        end else begin
            // 4-byte: plane above 0x10, overlong form, code points past 0x10FFFF
            if (c0[2:0] > 3'd4) begin
                c0 = c0 & 8'b11111011;
            end
            if (c0[2:0] == 3'd0 && c1[5:4] == 2'b00) begin
                c1 = c1 | 8'b00010000;
            end
            if (c0[2:0] == 3'd4 && c1[5:4] != 2'b00) begin
                c1 = c1 & 8'b11001111;
            end
        end
        r[0] = c0;
        r[1] = c1;
        return r;
    endfunction

endpackage

>>> design/utf8_stream_repair_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_stream_repair_top: rewrites a byte stream into valid UTF-8
//
// Input channel (s_axis): one raw byte per item, tlast marks the final byte
// of a buffer. Output channel (m_axis): one byte per item in input order,
// tlast on the final byte of the buffer, where tdata also carries the
// number of bytes in the repaired prefix (zero on other items).
// A multi-byte sequence is held until complete and then leaves repaired;
// an incomplete sequence cut off by tlast leaves unchanged and uncounted.
// A byte that completes a sequence passes the input register and then the
// output queue before it is shown on m_axis. Throughput: one byte per
// cycle, limited by the one-item-per-cycle read port of the eight-deep
// output queue; a new byte is taken while the queue has room for the four
// items a byte can release.
// When the receiver stalls, the queue fills and s_axis tready drops.
// Reset (synchronous, active low) empties the queue and drops any pending
// sequence; the length counter restarts at zero.
// ---------------------------------------------------------------------------
module utf8_stream_repair_top #(
    parameter int LENGTH_BITS = utf8r_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] out_byte, [39:8] repaired_len
    output logic        o_m_axis_tlast    // out_last
);
    import utf8r_pkg::*;

    t_push  push;
    t_entry head;
    logic   space_ok;

    // Sequence tracking and repair
    utf8r_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_byte     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .o_ready    (o_s_axis_tready),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    // Output queue
    utf8r_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_entry    (head)
    );

    assign o_m_axis_tdata = {head.len, head.data};
    assign o_m_axis_tlast = head.last;

endmodule

>>> design/utf8r_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8r_core: input register, sequence tracking and repair
// Holds bytes of a pending sequence, repairs it when complete and pushes
// the resulting items, with the running repaired length, to the queue.
// ---------------------------------------------------------------------------
module utf8r_core #(
    parameter int LENGTH_BITS = utf8r_pkg::LENGTH_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_ready,
    input  logic             i_space_ok,
    output utf8r_pkg::t_push o_push
);
    import utf8r_pkg::*;

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Sequence state
    logic [2:0][7:0]       r_held;
    logic [2:0][7:0]       n_held;
    logic [2:0]            r_need;
    logic [2:0]            n_need;
    logic [1:0]            r_hcnt;
    logic [1:0]            n_hcnt;
    logic [LENGTH_BITS-1:0] r_plen;
    logic [LENGTH_BITS-1:0] n_plen;

    logic                   fire;
    logic [2:0]             add_k;
    logic [LENGTH_BITS:0]   sum;
    logic [LENGTH_BITS-1:0] sat;
    logic [LEN_W-1:0]       len_out;
    t_push                  push;

    assign fire    = r_in_vld && i_space_ok;
    assign o_ready = !r_in_vld || fire;

    // Take a new item whenever the register is empty or drains this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    // Repaired bytes added by the registered item
    always_comb begin
        logic [3:0] lead_n;
        lead_n = lead_ones(r_in_byte);
        add_k  = 3'd0;
        if (r_hcnt == 2'd0) begin
            if (lead_n == 4'd0 || lead_n >= 4'd5) begin
                add_k = 3'd1;
            end
        end else if (({1'b0, r_hcnt} + 3'd1) >= r_need) begin
            add_k = r_need;
        end
    end

    // Saturating add of the repaired bytes of this item
    assign sum = {1'b0, r_plen} + {{(LENGTH_BITS-2){1'b0}}, add_k};
    assign sat = sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];

    generate
        if (LENGTH_BITS >= LEN_W) begin : g_len_trunc
            assign len_out = sat[LEN_W-1:0];
        end else begin : g_len_ext
            assign len_out = {{(LEN_W-LENGTH_BITS){1'b0}}, sat};
        end
    endgenerate

    // Sequence handling for the registered item
    always_comb begin
        logic [3:0] n;
        t_seq       seq;
        t_seq       rep;
        logic [2:0] cnt;
        logic [2:0] hp1;
        n      = lead_ones(r_in_byte);
        seq    = '0;
        rep    = '0;
        cnt    = 3'd0;
        hp1    = {1'b0, r_hcnt} + 3'd1;
        n_held = r_held;
        n_need = r_need;
        n_hcnt = r_hcnt;
        push   = '0;

        if (r_hcnt == 2'd0) begin
            // no pending sequence: classify the lead
            if (n == 4'd0) begin
                push.ent[0].data = r_in_byte;
                cnt   = 3'd1;
            end else if (n >= 4'd5) begin
                push.ent[0].data = r_in_byte & 8'b01111111;
                cnt   = 3'd1;
            end else begin
                n_held[0] = r_in_byte;
                n_hcnt    = 2'd1;
                n_need    = (n == 4'd1) ? 3'd2 : n[2:0];
            end
        end else begin
            seq[0] = r_held[0];
            seq[1] = (r_hcnt == 2'd1) ? r_in_byte : r_held[1];
            seq[2] = (r_hcnt == 2'd2) ? r_in_byte : r_held[2];
            seq[3] = r_in_byte;
            if (hp1 >= r_need) begin
                // sequence complete: repair and emit all of it
                rep = repair_seq(seq, r_need);
                for (int i = 0; i < MAX_EMIT; i++) begin
                    push.ent[i].data = rep[i];
                end
                cnt    = r_need;
                n_hcnt = 2'd0;
                n_need = 3'd0;
            end else begin
                n_held[r_hcnt] = r_in_byte;
                n_hcnt         = hp1[1:0];
            end
        end

        // incomplete tail at end of buffer goes out unchanged
        if (r_in_last && n_hcnt != 2'd0) begin
            for (int i = 0; i < 3; i++) begin
                push.ent[i].data = n_held[i];
            end
            cnt    = {1'b0, n_hcnt};
            n_hcnt = 2'd0;
            n_need = 3'd0;
        end

        // mark the final item of the buffer
        if (r_in_last) begin
            for (int i = 0; i < MAX_EMIT; i++) begin
                if (3'(i) == cnt - 3'd1) begin
                    push.ent[i].last = 1'b1;
                    push.ent[i].len  = len_out;
                end
            end
        end

        push.num = fire ? cnt : 3'd0;
        n_plen   = r_in_last ? '0 : sat;
    end

    assign o_push = push;

    // State update on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need <= 3'd0;
            r_hcnt <= 2'd0;
            r_plen <= '0;
        end else if (fire) begin
            r_need <= n_need;
            r_hcnt <= n_hcnt;
            r_plen <= n_plen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_held <= n_held;
        end
    end

endmodule

>>> design/utf8r_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8r_fifo: output item queue
// Takes up to four items per cycle, hands out one per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
module utf8r_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  utf8r_pkg::t_push  i_push,
    output logic              o_space_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output utf8r_pkg::t_entry o_entry
);
    import utf8r_pkg::*;

    t_entry [Q_DEPTH-1:0] r_mem;
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_PTR_W:0]     r_count;
    logic [Q_PTR_W:0]     n_count;
    logic                 pop;
    logic [Q_PTR_W:0]     free;

    assign pop        = o_valid && i_ready;
    assign o_valid    = r_count != '0;
    assign o_entry    = r_mem[r_rd];
    assign free       = (Q_PTR_W+1)'(Q_DEPTH) - r_count + {{Q_PTR_W{1'b0}}, pop};
    assign o_space_ok = free >= (Q_PTR_W+1)'(MAX_EMIT);
    assign n_count    = r_count + (Q_PTR_W+1)'(i_push.num) - {{Q_PTR_W{1'b0}}, pop};

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + Q_PTR_W'(i_push.num);
            r_rd    <= r_rd + {{(Q_PTR_W-1){1'b0}}, pop};
            r_count <= n_count;
        end
    end

    // Write the pushed items at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_EMIT; i++) begin
            if (3'(i) < i_push.num) begin
                r_mem[r_wr + Q_PTR_W'(i)] <= i_push.ent[i];
            end
        end
    end

endmodule

>>> sim/tb_utf8_stream_repair_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_utf8_stream_repair_top: self-checking bench for the UTF-8 stream repair
// Raw bytes go in on s_axis and repaired bytes come back on m_axis. A local
// predictor of the repair rules builds the expected output items for every
// accepted input item; the output monitor compares each item field by field.
// The run has a directed group, then random buffers, most of them well-formed
// sequences with random payload, under several sender and receiver idle mixes.
// ---------------------------------------------------------------------------
module tb_utf8_stream_repair_top;

    localparam int CLK_HALF       = 2;
    localparam int RST_CYCLES     = 11;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int LW             = utf8r_pkg::LEN_W;

    // One raw byte waiting to be offered
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } raw_byte_t;

    // One expected output item
    typedef struct packed {
        logic [LW-1:0] len;
        logic          last;
        logic [7:0]    data;
    } repaired_t;

    // Directed group: {last, byte}
    localparam logic [8:0] DIRECTED [25] = '{
        // ASCII extremes, eight leading ones, five leading ones
        9'h000, 9'h07F, 9'h0FF, 9'h1F8,
        // lone continuation with a non-follower, overlong 2-byte lead
        9'h080, 9'h000, 9'h0C1, 9'h1BF,
        // overlong 3-byte form, surrogate
        9'h0E0, 9'h000, 9'h000, 9'h0ED, 9'h0A0, 9'h180,
        // overlong 4-byte form, plane above 0x10
        9'h0F0, 9'h080, 9'h080, 9'h080, 9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
        // sequence cut off by the end of the buffer
        9'h0E2, 9'h182,
        // buffer that is a single lead byte
        9'h1F0
    };

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    logic [7:0]    i_s_axis_tdata = '0;    // [7:0] data_byte
    logic          i_s_axis_tlast = 1'b0;  // last_byte
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    logic [39:0]   o_m_axis_tdata;         // [7:0] out_byte, [39:8] repaired_len
    logic          o_m_axis_tlast;         // out_last

    raw_byte_t     raw_q [$];
    repaired_t     repaired_q [$];
    repaired_t     want;

    // Predictor state
    logic [7:0]    pend_bytes [3];
    int unsigned   pend_need = 0;
    int unsigned   pend_held = 0;
    logic [LW-1:0] len_so_far = '0;

    int unsigned   tx_idle_pct = 0;
    int unsigned   rx_stall_pct = 0;
    int unsigned   hold_reqs = 0;
    int unsigned   hold_seen = 0;
    int unsigned   rx_hold_left = 0;
    int unsigned   mismatch_cnt = 0;
    int unsigned   cycle_cnt = 0;

    utf8_stream_repair_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int unsigned count_lead_ones(input logic [7:0] b);
        int unsigned n;
        n = 0;
        while (n < 8 && b[7 - n]) n++;
        return n;
    endfunction

    // Saturating add to the repaired-prefix length
    function automatic void add_len(input int unsigned k);
        logic [LW:0] sum;
        sum = {1'b0, len_so_far} + k;
        len_so_far = sum[LW] ? '1 : sum[LW-1:0];
    endfunction

    // Expected output items for one accepted raw byte
    task automatic predict_repair(input logic [7:0] b, input logic lst);
        logic [7:0]  seq [4];
        logic [7:0]  emitted [$];
        logic [7:0]  c0;
        logic [7:0]  c1;
        int unsigned ones;
        int unsigned h;
        int unsigned k;
        repaired_t   r;
        if (pend_held == 0 || pend_need < 2 || pend_need > 4) begin
            ones = count_lead_ones(b);
            pend_held = 0;
            pend_need = 0;
            if (ones == 0) begin
                emitted.push_back(b);
                add_len(1);
            end else if (ones >= 5) begin
                emitted.push_back({1'b0, b[6:0]});
                add_len(1);
            end else begin
                pend_bytes[0] = b;
                pend_held = 1;
                pend_need = (ones == 1) ? 2 : ones;
            end
        end else begin
            h = pend_held;
            for (k = 0; k < h; k++) seq[k] = pend_bytes[k];
            seq[h] = b;
            if (h + 1 >= pend_need) begin
                // sequence complete: force followers, then patch lead and byte 1
                ones = count_lead_ones(seq[0]);
                for (k = 1; k < pend_need; k++) seq[k] = {2'b10, seq[k][5:0]};
                c0 = seq[0];
                c1 = seq[1];
                if (ones == 1 || ones == 2) begin
                    if (ones == 1) c0 = {3'b110, c0[4:0]};
                    if (c0[4:1] == 4'd0) c0[1] = 1'b1;
                end else if (ones == 3) begin
                    if (c0[3:0] == 4'h0 && !c1[5]) c1[5] = 1'b1;
                    if (c0[3:0] == 4'hD && c1[5]) c1[5] = 1'b0;
                end else begin
                    if (c0[2:0] > 3'd4) c0[2] = 1'b0;
                    if (c0[2:0] == 3'd0 && c1[5:4] == 2'b00) c1[4] = 1'b1;
                    if (c0[2:0] == 3'd4 && c1[5:4] != 2'b00) c1[5:4] = 2'b00;
                end
                seq[0] = c0;
                seq[1] = c1;
                for (k = 0; k < pend_need; k++) emitted.push_back(seq[k]);
                add_len(pend_need);
                pend_held = 0;
                pend_need = 0;
            end else begin
                pend_bytes[h] = b;
                pend_held = h + 1;
            end
        end
        // incomplete tail leaves as it came, uncounted
        if (lst && pend_held != 0) begin
            for (k = 0; k < pend_held; k++) emitted.push_back(pend_bytes[k]);
            pend_held = 0;
            pend_need = 0;
        end
        foreach (emitted[i]) begin
            r.data = emitted[i];
            r.last = 1'b0;
            r.len  = '0;
            if (lst && i == emitted.size() - 1) begin
                r.last = 1'b1;
                r.len  = len_so_far;
            end
            repaired_q.push_back(r);
        end
        if (lst && emitted.size() != 0) len_so_far = '0;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic lst);
        raw_byte_t item;
        item.data = b;
        item.last = lst;
        raw_q.push_back(item);
    endtask

    // Random buffers of one to six units; mostly well-formed sequences
    task automatic fill_buffers(input int unsigned target);
        int unsigned added;
        int unsigned units;
        int unsigned u;
        int unsigned kind;
        int unsigned seq_len;
        int unsigned keep;
        int unsigned k;
        logic [31:0] rnd;
        logic [7:0]  unit_bytes [$];
        added = 0;
        while (added < target) begin
            units = $urandom_range(1, 6);
            for (u = 0; u < units; u++) begin
                unit_bytes.delete();
                kind = $urandom_range(0, 9);
                rnd  = $urandom;
                if (kind < 3) begin
                    unit_bytes.push_back({1'b0, rnd[6:0]});
                end else if (kind < 8) begin
                    seq_len = $urandom_range(2, 4);
                    if (kind == 7) begin
                        seq_len = 2;
                        unit_bytes.push_back({2'b10, rnd[5:0]});
                    end else if (seq_len == 2) begin
                        unit_bytes.push_back({3'b110, rnd[4:0]});
                    end else if (seq_len == 3) begin
                        unit_bytes.push_back({4'b1110, rnd[3:0]});
                    end else begin
                        unit_bytes.push_back({5'b11110, rnd[2:0]});
                    end
                    for (k = 1; k < seq_len; k++) begin
                        rnd = $urandom;
                        if ($urandom_range(0, 4) == 0) begin
                            unit_bytes.push_back(rnd[7:0]);
                        end else begin
                            unit_bytes.push_back({2'b10, rnd[5:0]});
                        end
                    end
                    // now and then the buffer ends inside a sequence
                    if (u == units - 1 && $urandom_range(0, 5) == 0) begin
                        keep = $urandom_range(1, seq_len - 1);
                        while (unit_bytes.size() > keep) void'(unit_bytes.pop_back());
                    end
                end else if (kind == 8) begin
                    unit_bytes.push_back(rnd[7:0]);
                end else begin
                    unit_bytes.push_back({5'b11111, rnd[2:0]});
                end
                foreach (unit_bytes[i]) begin
                    queue_byte(unit_bytes[i], u == units - 1 && i == unit_bytes.size() - 1);
                    added++;
                end
            end
        end
    endtask

    // Sender pauses here until the block has returned everything
    task automatic wait_drained();
        while (raw_q.size() != 0 || i_s_axis_tvalid || repaired_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                predict_repair(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (raw_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_s_axis_tdata  <= raw_q[0].data;
                i_s_axis_tlast  <= raw_q[0].last;
                i_s_axis_tvalid <= 1'b1;
                void'(raw_q.pop_front());
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen    <= hold_reqs;
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Output monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (repaired_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("%0t: unexpected item byte=%02h last=%0b len=%0d", $realtime,
                                 o_m_axis_tdata[7:0], o_m_axis_tlast, o_m_axis_tdata[39:8]);
                    end
                end else begin
                    want = repaired_q.pop_front();
                    if (o_m_axis_tdata[7:0] !== want.data || o_m_axis_tlast !== want.last
                            || o_m_axis_tdata[39:8] !== want.len) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $display("%0t: mismatch exp byte=%02h last=%0b len=%0d",
                                     $realtime, want.data, want.last, want.len);
                            $display("%0t:          got byte=%02h last=%0b len=%0d",
                                     $realtime, o_m_axis_tdata[7:0], o_m_axis_tlast,
                                     o_m_axis_tdata[39:8]);
                        end
                    end
                end
            end
            i_m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Reset, then the stimulus phases
    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[i]) queue_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        wait_drained();

        // no idling; receiver holds off at first so the queue backs up
        hold_reqs++;
        fill_buffers(90);
        wait_drained();

        tx_idle_pct = 68;
        fill_buffers(85);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 68;
        fill_buffers(85);
        wait_drained();

        tx_idle_pct  = 35;
        rx_stall_pct = 35;
        fill_buffers(85);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0 && repaired_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
